[rtl/core/assert_macros.svh]
// assertion macros used by the checker file of the key/value cache
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define LKV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define LKV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/lkv_pkg.sv]
// shared types and constants of the lru key/value cache
// no dependencies; used by the top level and its checker

package lkv_pkg;

   localparam int FUNC_W      = 2;
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam int CNT_W       = 32;
   localparam int OCC_W       = 5;
   localparam int CAP_W       = 5;
   localparam int DEF_ENTRIES = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // request operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ERASE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_value;
      logic               evicted;
      logic [OCC_W-1:0]   occupancy;
      logic [CNT_W-1:0]   hit_total;
      logic [CNT_W-1:0]   miss_total;
      logic [CNT_W-1:0]   eviction_total;
   } rsp_type;

endpackage

[rtl/core/lru_key_value_cache.sv]
// fully associative key/value cache with least-recently-used replacement
// depends on lkv_pkg for the transaction types, codes and defaults
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  lkv_pkg::req_type (func, key, value)
//  rsp_     out        rsp_valid/rsp_stall  lkv_pkg::rsp_type (found .. eviction_total)
//  csr_     in         csr_we               csr_wdata = capacity_in_use
//
// each transaction is accepted, then its key is compared with the entries one a
// cycle through the single read port of the key and value memories with the one
// key comparator, then it is applied
// synchronous reset clears valid bits, ranks, occupancy and counters, and sets
// the capacity to 16; the key and value memories are not cleared
// the result sits in an output register, so a stalled rsp_ side does not stop
// the next request from being accepted and scanned; only the apply step waits

module lru_key_value_cache #(
   parameter int ENTRIES = lkv_pkg::DEF_ENTRIES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lkv_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lkv_pkg::rsp_type         rsp_data,
   input  logic                     csr_we,
   input  logic [lkv_pkg::CAP_W-1:0] csr_wdata
);

   // slot index and rank width
   localparam int IW = $clog2(ENTRIES);
   // occupancy count width, holds ENTRIES itself
   localparam int CW = $clog2(ENTRIES + 1);
   // width for capacity compares
   localparam int MW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;
   // scan counter width, holds ENTRIES itself
   localparam int SW = IW + 1;
   localparam logic [SW-1:0] SCAN_LAST = SW'(ENTRIES);

   localparam int VW = lkv_pkg::VALUE_W;
   localparam int KW = lkv_pkg::KEY_W;
   localparam int NW = lkv_pkg::CNT_W;

   // results of the scan, gathered one entry per cycle
   typedef struct packed {
      logic          hit_fnd;
      logic [IW-1:0] hit_slot;
      logic [IW-1:0] hit_rank;
      logic [VW-1:0] hit_val;
      logic          old_fnd;
      logic [IW-1:0] old_slot;
      logic [IW-1:0] old_rank;
      logic          free_fnd;
      logic [IW-1:0] free_slot;
   } track_type;

   function automatic logic [NW-1:0] sat_inc(input logic [NW-1:0] c);
      return (c == '1) ? c : NW'(c + 1'b1);
   endfunction

   // sequencer
   lkv_pkg::state_type state_ff, state_in;
   logic                accept;
   logic                searching;
   logic                apply_fire;

   logic [SW-1:0] scan_ff, scan_in;
   logic [IW-1:0] rd_addr;
   logic          pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0] pipe_idx_ff;

   lkv_pkg::req_type req_ff;

   // entry storage
   logic [KW-1:0] key_mem_ff   [ENTRIES];
   logic [VW-1:0] value_mem_ff [ENTRIES];
   logic [KW-1:0] key_rd_ff;
   logic [VW-1:0] value_rd_ff;
   logic          key_we, val_we;
   logic [IW-1:0] wr_addr;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0]      rank_ff [ENTRIES];
   logic [IW-1:0]      rank_in [ENTRIES];

   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] hit_cnt_ff, hit_cnt_in;
   logic [NW-1:0] miss_cnt_ff, miss_cnt_in;
   logic [NW-1:0] evict_cnt_ff, evict_cnt_in;
   logic [lkv_pkg::CAP_W-1:0] cap_ff;

   track_type track_ff, track_in;
   logic          scan_vld;
   logic [IW-1:0] scan_rank;

   // apply step
   logic [MW-1:0] cap_w, ent_w, eff_cap, occ_w;
   logic          need_evict;
   logic [IW-1:0] ins_slot;

   lkv_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // ---------------------------------------------------------------
   // state machine
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            if (req_valid) state_in = lkv_pkg::ST_SEARCH;
         end
         lkv_pkg::ST_SEARCH: begin
            if (scan_ff == SCAN_LAST) state_in = lkv_pkg::ST_APPLY;
         end
         lkv_pkg::ST_APPLY: begin
            // wait for the output register to empty
            if (!(rsp_valid_ff && rsp_stall)) state_in = lkv_pkg::ST_IDLE;
         end
         default: state_in = lkv_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      searching  = 1'b0;
      apply_fire = 1'b0;
      unique case (state_ff)
         lkv_pkg::ST_IDLE:   req_stall  = 1'b0;
         lkv_pkg::ST_SEARCH: searching  = 1'b1;
         lkv_pkg::ST_APPLY:  apply_fire = !(rsp_valid_ff && rsp_stall);
         default: ;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // scan: address issued one cycle, data compared the next
   // ---------------------------------------------------------------
   assign rd_addr     = scan_ff[IW-1:0];
   assign scan_in     = accept ? '0 : (searching ? SW'(scan_ff + 1'b1) : scan_ff);
   assign pipe_vld_in = searching && (scan_ff < SCAN_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         scan_ff     <= scan_in;
         pipe_vld_ff <= pipe_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_idx_ff <= rd_addr;
      if (accept) req_ff <= req_data;
   end

   // key and value memories, one write and one registered read port each
   always_ff @(posedge clock) begin
      if (key_we) key_mem_ff[wr_addr] <= req_ff.key;
      if (val_we) value_mem_ff[wr_addr] <= req_ff.value;
      key_rd_ff   <= key_mem_ff[rd_addr];
      value_rd_ff <= value_mem_ff[rd_addr];
   end

   assign scan_vld  = valid_ff[pipe_idx_ff];
   assign scan_rank = rank_ff[pipe_idx_ff];

   // hit, least recent and first free slot, gathered as entries stream by
   always_comb begin
      track_in = track_ff;
      if (accept) begin
         track_in.hit_fnd  = 1'b0;
         track_in.old_fnd  = 1'b0;
         track_in.free_fnd = 1'b0;
      end else if (pipe_vld_ff) begin
         if (scan_vld && (key_rd_ff == req_ff.key) && !track_ff.hit_fnd) begin
            track_in.hit_fnd  = 1'b1;
            track_in.hit_slot = pipe_idx_ff;
            track_in.hit_rank = scan_rank;
            track_in.hit_val  = value_rd_ff;
         end
         // first slot wins on equal ranks
         if (scan_vld && (!track_ff.old_fnd || (scan_rank > track_ff.old_rank))) begin
            track_in.old_fnd  = 1'b1;
            track_in.old_slot = pipe_idx_ff;
            track_in.old_rank = scan_rank;
         end
         if (!scan_vld && !track_ff.free_fnd) begin
            track_in.free_fnd  = 1'b1;
            track_in.free_slot = pipe_idx_ff;
         end
      end
   end

   // only the found flags are reset; slots, ranks and value follow them
   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff.hit_fnd  <= 1'b0;
         track_ff.old_fnd  <= 1'b0;
         track_ff.free_fnd <= 1'b0;
      end else begin
         track_ff.hit_fnd  <= track_in.hit_fnd;
         track_ff.old_fnd  <= track_in.old_fnd;
         track_ff.free_fnd <= track_in.free_fnd;
      end
      track_ff.hit_slot  <= track_in.hit_slot;
      track_ff.hit_rank  <= track_in.hit_rank;
      track_ff.hit_val   <= track_in.hit_val;
      track_ff.old_slot  <= track_in.old_slot;
      track_ff.old_rank  <= track_in.old_rank;
      track_ff.free_slot <= track_in.free_slot;
   end

   // ---------------------------------------------------------------
   // apply: update valid bits, ranks, counters and build the result
   // ---------------------------------------------------------------
   // capacity zero acts as one, above ENTRIES acts as ENTRIES
   assign cap_w   = MW'(cap_ff);
   assign ent_w   = MW'(ENTRIES);
   assign eff_cap = (cap_ff == '0) ? MW'(1) : ((cap_w > ent_w) ? ent_w : cap_w);

   assign need_evict = (MW'(count_ff) >= eff_cap);

   // evicted slot is reused unless a lower free slot exists
   assign ins_slot = !need_evict ? track_ff.free_slot :
                     ((track_ff.free_fnd && (track_ff.free_slot < track_ff.old_slot)) ?
                      track_ff.free_slot : track_ff.old_slot);

   always_comb begin
      valid_in     = valid_ff;
      rank_in      = rank_ff;
      count_in     = count_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      key_we       = 1'b0;
      val_we       = 1'b0;
      wr_addr      = track_ff.hit_slot;
      rsp_in.found      = 1'b0;
      rsp_in.read_value = '0;
      rsp_in.evicted    = 1'b0;

      unique case (req_ff.func)
         lkv_pkg::FUNC_PUT: begin
            if (track_ff.hit_fnd) begin
               // update in place and make most recent
               val_we       = apply_fire;
               rsp_in.found = 1'b1;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ff[i] && (rank_ff[i] < track_ff.hit_rank))
                     rank_in[i] = IW'(rank_ff[i] + 1'b1);
                  if (IW'(i) == track_ff.hit_slot) rank_in[i] = '0;
               end
            end else begin
               // insert as most recent, dropping the least recent if full
               key_we  = apply_fire;
               val_we  = apply_fire;
               wr_addr = ins_slot;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (need_evict && (IW'(i) == track_ff.old_slot)) begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end else if (valid_ff[i]) begin
                     rank_in[i] = IW'(rank_ff[i] + 1'b1);
                  end
                  if (IW'(i) == ins_slot) begin
                     valid_in[i] = 1'b1;
                     rank_in[i]  = '0;
                  end
               end
               if (need_evict) begin
                  evict_cnt_in   = sat_inc(evict_cnt_ff);
                  rsp_in.evicted = 1'b1;
               end else begin
                  count_in = CW'(count_ff + 1'b1);
               end
            end
         end
         lkv_pkg::FUNC_GET: begin
            if (track_ff.hit_fnd) begin
               hit_cnt_in        = sat_inc(hit_cnt_ff);
               rsp_in.found      = 1'b1;
               rsp_in.read_value = track_ff.hit_val;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ff[i] && (rank_ff[i] < track_ff.hit_rank))
                     rank_in[i] = IW'(rank_ff[i] + 1'b1);
                  if (IW'(i) == track_ff.hit_slot) rank_in[i] = '0;
               end
            end else begin
               miss_cnt_in = sat_inc(miss_cnt_ff);
            end
         end
         lkv_pkg::FUNC_ERASE: begin
            if (track_ff.hit_fnd) begin
               // remove and close the gap behind it
               rsp_in.found = 1'b1;
               count_in     = CW'(count_ff - 1'b1);
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ff[i] && (rank_ff[i] > track_ff.hit_rank))
                     rank_in[i] = IW'(rank_ff[i] - 1'b1);
                  if (IW'(i) == track_ff.hit_slot) begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end
               end
            end
         end
         default: ; // unused code: nothing changes
      endcase

      occ_w                 = MW'(count_in);
      rsp_in.occupancy      = occ_w[lkv_pkg::OCC_W-1:0];
      rsp_in.hit_total      = hit_cnt_in;
      rsp_in.miss_total     = miss_cnt_in;
      rsp_in.eviction_total = evict_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else if (apply_fire) begin
         valid_ff     <= valid_in;
         rank_ff      <= rank_in;
         count_ff     <= count_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         evict_cnt_ff <= evict_cnt_in;
      end
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkv_pkg::CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------
   assign rsp_valid_in = apply_fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_fire) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/lkv_checker.sv]
// port-level assertions for the lru key/value cache, bound to its top level
// depends on lkv_pkg and assert_macros.svh
`include "assert_macros.svh"

module lkv_checker #(
   parameter int ENTRIES = lkv_pkg::DEF_ENTRIES
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input lkv_pkg::req_type          req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input lkv_pkg::rsp_type          rsp_data,
   input logic                      csr_we,
   input logic [lkv_pkg::CAP_W-1:0] csr_wdata
);

   logic req_fire;
   logic unused_ok;

   assign req_fire  = req_valid && !req_stall;
   assign unused_ok = csr_we ^ (^csr_wdata) ^ (^req_data);

   // a waiting result is not dropped
   `LKV_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped")

   // one transaction at a time: busy right after an accept
   `LKV_ASSERT_NXT(a_busy_after_req, clock, reset, req_fire, req_stall, "accepted back to back")

   // read value only on a found key
   `LKV_ASSERT_IMP(a_rd_zero, clock, reset, rsp_valid && !rsp_data.found,
      rsp_data.read_value == '0, "read value without a hit")

   // an evicting put never found its key
   `LKV_ASSERT_IMP(a_evict_miss, clock, reset, rsp_valid && rsp_data.evicted,
      !rsp_data.found, "eviction on a found key")

   // occupancy never exceeds the entry count
   `LKV_ASSERT_IMP(a_occ_range, clock, reset, rsp_valid,
      rsp_data.occupancy <= ENTRIES, "occupancy above entry count")

endmodule

bind lru_key_value_cache lkv_checker #(.ENTRIES(ENTRIES)) u_lkv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_we    (csr_we),
   .csr_wdata (csr_wdata)
);

[verif/tb.sv]
// self-checking testbench for lru_key_value_cache: directed and random put/get/erase traffic
// depends on lkv_pkg and the rtl top level; a scoreboard class mirrors the cache contents
`timescale 1ns / 1ps

module tb;
   import lkv_pkg::*;

   localparam int QUIET_LIMIT = 5000;   // cycles with no transaction before giving up
   localparam int HOLD_CYCLES = 400;    // long receiver hold-off
   localparam int SETTLE      = 40;     // settling wait after the last result
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 100;

   // mirror of the cache: contents, recency ages, counters and expected results
   class cache_tracker;
      bit                 slot_used [DEF_ENTRIES];
      logic [KEY_W-1:0]   slot_key  [DEF_ENTRIES];
      logic [VALUE_W-1:0] slot_val  [DEF_ENTRIES];
      int unsigned        slot_age  [DEF_ENTRIES];
      int unsigned        used_count;
      int unsigned        capacity;
      logic [CNT_W-1:0]   hits;
      logic [CNT_W-1:0]   misses;
      logic [CNT_W-1:0]   evictions;
      rsp_type            awaited_rsp [$];
      int unsigned        errors;

      function new();
         for (int i = 0; i < DEF_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_age[i]  = 0;
         end
         used_count = 0;
         capacity   = CAP_RESET;
         hits       = '0;
         misses     = '0;
         evictions  = '0;
         errors     = 0;
      endfunction

      function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
         return (c == '1) ? c : c + 1'b1;
      endfunction

      // move slot s to most recent, aging only the younger entries
      function void promote(int s);
         int unsigned r;
         r = slot_age[s];
         for (int i = 0; i < DEF_ENTRIES; i++)
            if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
         slot_age[s] = 0;
      endfunction

      // drop slot s and close the gap behind it
      function void retire(int s);
         int unsigned r;
         r = slot_age[s];
         slot_used[s] = 1'b0;
         slot_age[s]  = 0;
         for (int i = 0; i < DEF_ENTRIES; i++)
            if (slot_used[i] && slot_age[i] > r) slot_age[i]--;
         if (used_count > 0) used_count--;
      endfunction

      function void note_request(req_type r);
         rsp_type     want;
         int          hit_slot;
         int          victim;
         int          spare;
         int unsigned limit;
         want     = '0;
         hit_slot = -1;
         for (int i = 0; i < DEF_ENTRIES; i++)
            if (hit_slot < 0 && slot_used[i] && slot_key[i] == r.key) hit_slot = i;
         limit = (capacity < 1) ? 1 : (capacity > DEF_ENTRIES) ? DEF_ENTRIES : capacity;

         case (r.func)
            FUNC_PUT: begin
               if (hit_slot >= 0) begin
                  slot_val[hit_slot] = r.value;
                  promote(hit_slot);
                  want.found = 1'b1;
               end else begin
                  // full at the capacity in use: evict exactly one, the oldest
                  if (used_count >= limit) begin
                     victim = -1;
                     for (int i = 0; i < DEF_ENTRIES; i++)
                        if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                           victim = i;
                     if (victim >= 0) begin
                        retire(victim);
                        evictions    = bump(evictions);
                        want.evicted = 1'b1;
                     end
                  end
                  spare = -1;
                  for (int i = 0; i < DEF_ENTRIES; i++)
                     if (spare < 0 && !slot_used[i]) spare = i;
                  if (spare >= 0) begin
                     for (int i = 0; i < DEF_ENTRIES; i++)
                        if (slot_used[i]) slot_age[i]++;
                     slot_used[spare] = 1'b1;
                     slot_key[spare]  = r.key;
                     slot_val[spare]  = r.value;
                     slot_age[spare]  = 0;
                     used_count++;
                  end
               end
            end
            FUNC_GET: begin
               if (hit_slot >= 0) begin
                  hits = bump(hits);
                  promote(hit_slot);
                  want.found      = 1'b1;
                  want.read_value = slot_val[hit_slot];
               end else begin
                  misses = bump(misses);
               end
            end
            FUNC_ERASE: begin
               if (hit_slot >= 0) begin
                  retire(hit_slot);
                  want.found = 1'b1;
               end
            end
            default: ;
         endcase

         want.occupancy      = OCC_W'(used_count);
         want.hit_total      = hits;
         want.miss_total     = misses;
         want.eviction_total = evictions;
         awaited_rsp.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: result with none expected, actual %h", $time, got);
            errors++;
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("found", want.found, got.found);
         compare_field("read_value", want.read_value, got.read_value);
         compare_field("evicted", want.evicted, got.evicted);
         compare_field("occupancy", want.occupancy, got.occupancy);
         compare_field("hit_total", want.hit_total, got.hit_total);
         compare_field("miss_total", want.miss_total, got.miss_total);
         compare_field("eviction_total", want.eviction_total, got.eviction_total);
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;

   cache_tracker board = new();

   bit               no_idle;        // both sides run back to back while set
   int               rsp_hold_len;   // one-shot long hold-off for the receiver
   int               pool_span;
   logic [KEY_W-1:0] key_pool [32];

   lru_key_value_cache uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      return no_idle ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic req_type make_req(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                        logic [VALUE_W-1:0] v);
      req_type r;
      r.func  = f;
      r.key   = k;
      r.value = v;
      return r;
   endfunction

   // mostly keys from a small pool so that hits, updates and evictions are common
   function automatic req_type pick_request();
      req_type     r;
      int unsigned roll;
      roll   = $urandom_range(0, 99);
      r.func = (roll < 45) ? FUNC_PUT : (roll < 80) ? FUNC_GET : FUNC_ERASE;
      r.key  = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom())
                                           : key_pool[$urandom_range(0, pool_span - 1)];
      case ($urandom_range(0, 9))
         0:       r.value = '0;
         1:       r.value = '1;
         default: r.value = VALUE_W'($urandom());
      endcase
      return r;
   endfunction

   // offer one transaction after an idle gap and wait until it is taken
   task automatic send_req(input req_type r, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (board.awaited_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input int unsigned c);
      drain_and_idle();
      csr_we    <= 1'b1;
      csr_wdata <= CAP_W'(c);
      @(posedge clock);
      csr_we <= 1'b0;
      board.capacity = c;
      @(posedge clock);
   endtask

   // result side: random stall per transaction, checked at the accepting edge
   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = (rsp_hold_len > 0) ? rsp_hold_len : pick_gap();
         rsp_hold_len = 0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_result(rsp_data);
      end
   end

   // give up when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase_cap [PHASES];
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_wdata    = CAP_RESET;
      no_idle      = 1'b0;
      rsp_hold_len = 0;
      pool_span    = 32;

      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 32'h0000_0001;
      key_pool[3] = 32'h8000_0000;
      for (int i = 4; i < 32; i++) key_pool[i] = KEY_W'($urandom());

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty cache, extreme keys and values, update, erase of present and absent
      send_req(make_req(FUNC_GET,   '0, '0), pick_gap());
      send_req(make_req(FUNC_ERASE, '0, '0), pick_gap());
      send_req(make_req(FUNC_PUT,   '0, '0), pick_gap());
      send_req(make_req(FUNC_PUT,   '1, '1), pick_gap());
      send_req(make_req(FUNC_GET,   '1, '0), pick_gap());
      send_req(make_req(FUNC_GET,   '0, '1), pick_gap());
      send_req(make_req(FUNC_PUT,   '0, 32'hA5A5_A5A5), pick_gap());
      send_req(make_req(FUNC_GET,   '0, '0), pick_gap());
      send_req(make_req(FUNC_ERASE, '1, '0), pick_gap());
      send_req(make_req(FUNC_ERASE, '1, '0), pick_gap());
      send_req(make_req(FUNC_GET,   '1, '0), pick_gap());

      // single entry capacity: every new key evicts
      write_capacity(1);
      send_req(make_req(FUNC_PUT, 32'd1, 32'h11), pick_gap());
      send_req(make_req(FUNC_PUT, 32'd2, 32'h22), pick_gap());
      send_req(make_req(FUNC_GET, 32'd1, '0), pick_gap());
      send_req(make_req(FUNC_GET, 32'd2, '0), pick_gap());

      // fill four, then lower the capacity below occupancy
      write_capacity(4);
      send_req(make_req(FUNC_PUT, 32'd3, 32'h33), pick_gap());
      send_req(make_req(FUNC_PUT, 32'd4, 32'h44), pick_gap());
      send_req(make_req(FUNC_PUT, 32'd5, 32'h55), pick_gap());
      send_req(make_req(FUNC_GET, 32'd2, '0), pick_gap());
      write_capacity(2);
      send_req(make_req(FUNC_PUT,   32'd6, 32'h66), pick_gap());
      send_req(make_req(FUNC_GET,   32'd3, '0), pick_gap());
      send_req(make_req(FUNC_PUT,   32'd7, 32'h77), pick_gap());
      send_req(make_req(FUNC_ERASE, 32'd2, '0), pick_gap());
      send_req(make_req(FUNC_PUT,   32'd8, 32'h88), pick_gap());

      phase_cap[0] = DEF_ENTRIES;
      phase_cap[1] = 1;
      phase_cap[2] = $urandom_range(3, 15);
      phase_cap[3] = DEF_ENTRIES;
      phase_cap[4] = $urandom_range(3, 15);
      phase_cap[5] = 2;

      for (int ph = 0; ph < PHASES; ph++) begin
         write_capacity(phase_cap[ph]);
         pool_span = $urandom_range(4, 32);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            no_idle = (n < 15);
            // receiver holds off while requests keep coming, so the input backs up
            if (ph == 2 && n == 30) rsp_hold_len = HOLD_CYCLES;
            // sender waits for the pipeline to empty completely
            if (ph == 3 && n == 50) drain_and_idle();
            send_req(pick_request(), pick_gap());
         end
      end

      no_idle = 1'b0;
      req_valid <= 1'b0;
      while (board.awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (board.errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/lkv_pkg.sv
rtl/core/lru_key_value_cache.sv
rtl/core/lkv_checker.sv
verif/tb.sv
